@@ sv/radial_distortion_bilinear_remap_unit_macros.svh @@
// Assertion macros shared by the remap unit files.
`ifndef RADIAL_DISTORTION_BILINEAR_REMAP_UNIT_MACROS_SVH
`define RADIAL_DISTORTION_BILINEAR_REMAP_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RDBR_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RDBR_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDBR_CHECK(lbl, prop, msg)
`define RDBR_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/rdbr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rdbr_pkg;
    localparam int IMG_WIDTH  = 128;
    localparam int IMG_HEIGHT = 128;
    localparam int BANK_DEPTH = (IMG_WIDTH / 2) * (IMG_HEIGHT / 2);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int PIX_W      = 32;
    localparam int CFG_W      = 21;
    localparam int NUM_W      = 15;
    localparam int QUOT_W     = 31;
    localparam int DSQ_W      = 20;
    localparam int DIV_STAGES = QUOT_W;
    localparam int R2_W       = 26;
    localparam int R4_W       = 36;
    localparam int Z_W        = 42;
    localparam int P_W        = 52;
    localparam int LATENCY    = DIV_STAGES + 9;
    localparam logic [QUOT_W-1:0] R2_MAX = 31'h03FF_FFFF;
    localparam logic signed [Z_W-1:0] Q_ONE = 42'sd65536;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        REG_COEF_A        = 3'd0,
        REG_COEF_B        = 3'd1,
        REG_RADIUS_SCALE  = 3'd2,
        REG_REGION_LEFT   = 3'd3,
        REG_REGION_TOP    = 3'd4,
        REG_REGION_RIGHT  = 3'd5,
        REG_REGION_BOTTOM = 3'd6,
        REG_CHANNEL_COUNT = 3'd7
    } reg_idx_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [6:0]         x;
        logic [6:0]         y;
        logic [PIX_W-1:0]   data;
        logic signed [7:0]  dx;
        logic signed [7:0]  dy;
    } item_t;

    typedef struct packed
    {
        logic signed [20:0] coef_a;
        logic signed [19:0] coef_b;
        logic [DSQ_W-1:0]   s_sq;
        logic [6:0]         lx;
        logic [6:0]         ly;
        logic [7:0]         hx;
        logic [7:0]         hy;
        logic [6:0]         cx;
        logic [6:0]         cy;
        logic [2:0]         nch;
    } cfg_t;
endpackage
`default_nettype wire

@@ sv/rdbr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rdbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ sv/rdbr_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rdbr_div import rdbr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  item_t             in_item,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DSQ_W-1:0]  dsq,
    output logic              out_vld,
    output item_t             out_item,
    output logic [QUOT_W-1:0] out_quot
);
    logic              vld_reg   [DIV_STAGES];
    item_t             item_reg  [DIV_STAGES];
    logic [DSQ_W-1:0]  rem_reg   [DIV_STAGES];
    logic [QUOT_W-1:0] quot_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] num_reg   [DIV_STAGES];
    logic              vld_prev  [DIV_STAGES];
    item_t             item_prev [DIV_STAGES];
    logic [DSQ_W-1:0]  rem_prev  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_prev [DIV_STAGES];
    logic [QUOT_W-1:0] num_prev  [DIV_STAGES];
    logic [DSQ_W:0]    trial     [DIV_STAGES];
    logic              take      [DIV_STAGES];
    logic [DSQ_W-1:0]  rem_next  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_next [DIV_STAGES];
    logic [QUOT_W-1:0] num_next  [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            if (g == 0)
            begin : g_first
                assign vld_prev[g]  = in_vld;
                assign item_prev[g] = in_item;
                assign rem_prev[g]  = '0;
                assign quot_prev[g] = '0;
                assign num_prev[g]  = {in_num, {(QUOT_W - NUM_W){1'b0}}};
            end
            else
            begin : g_rest
                assign vld_prev[g]  = vld_reg[g-1];
                assign item_prev[g] = item_reg[g-1];
                assign rem_prev[g]  = rem_reg[g-1];
                assign quot_prev[g] = quot_reg[g-1];
                assign num_prev[g]  = num_reg[g-1];
            end

            assign trial[g]     = {rem_prev[g], num_prev[g][QUOT_W-1]};
            assign take[g]      = trial[g] >= {1'b0, dsq};
            assign rem_next[g]  = take[g] ? DSQ_W'(trial[g] - {1'b0, dsq})
                                          : trial[g][DSQ_W-1:0];
            assign quot_next[g] = {quot_prev[g][QUOT_W-2:0], take[g]};
            assign num_next[g]  = {num_prev[g][QUOT_W-2:0], 1'b0};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else
                begin
                    vld_reg[g] <= vld_prev[g];
                end
            end

            always_ff @(posedge clk)
            begin
                item_reg[g] <= item_prev[g];
                rem_reg[g]  <= rem_next[g];
                quot_reg[g] <= quot_next[g];
                num_reg[g]  <= num_next[g];
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_item = item_reg[DIV_STAGES-1];
    assign out_quot = quot_reg[DIV_STAGES-1];
endmodule
`default_nettype wire

@@ sv/rdbr_warp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rdbr_warp import rdbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_vld,
    input  item_t                 in_item,
    input  logic [QUOT_W-1:0]     in_quot,
    output logic                  out_vld,
    output item_t                 out_item,
    output logic signed [P_W-1:0] out_px,
    output logic signed [P_W-1:0] out_py
);
    logic [R2_W-1:0]          r2;
    logic [2*R2_W-1:0]        r2_sq;
    logic signed [47:0]       ar2_prod;
    logic                     vld_a_reg;
    item_t                    item_a_reg;
    logic [R4_W-1:0]          r4_a_reg;
    logic signed [31:0]       ar2s_a_reg;

    logic signed [38:0]       blo_next;
    logic signed [38:0]       bhi_next;
    logic                     vld_b_reg;
    item_t                    item_b_reg;
    logic signed [38:0]       blo_b_reg;
    logic signed [38:0]       bhi_b_reg;
    logic signed [31:0]       ar2s_b_reg;

    logic signed [57:0]       bsum;
    logic signed [Z_W-1:0]    z_next;
    logic                     vld_c_reg;
    item_t                    item_c_reg;
    logic signed [Z_W-1:0]    z_c_reg;

    logic signed [Z_W+7:0]    dxz;
    logic signed [Z_W+7:0]    dyz;
    logic signed [P_W-1:0]    px_next;
    logic signed [P_W-1:0]    py_next;
    logic                     vld_d_reg;
    item_t                    item_d_reg;
    logic signed [P_W-1:0]    px_d_reg;
    logic signed [P_W-1:0]    py_d_reg;

    assign r2       = (in_quot > R2_MAX) ? R2_W'(R2_MAX) : in_quot[R2_W-1:0];
    assign r2_sq    = r2 * r2;
    assign ar2_prod = cfg.coef_a * $signed({1'b0, r2});

    assign blo_next = cfg.coef_b * $signed({1'b0, r4_a_reg[17:0]});
    assign bhi_next = cfg.coef_b * $signed({1'b0, r4_a_reg[35:18]});

    assign bsum   = (58'(bhi_b_reg) <<< 18) + 58'(blo_b_reg);
    assign z_next = bsum[57:16] + 42'(ar2s_b_reg) + Q_ONE;

    assign dxz     = item_c_reg.dx * z_c_reg;
    assign dyz     = item_c_reg.dy * z_c_reg;
    assign px_next = 52'(dxz) + $signed({29'b0, cfg.cx, 16'b0});
    assign py_next = 52'(dyz) + $signed({29'b0, cfg.cy, 16'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item_a_reg <= in_item;
        r4_a_reg   <= r2_sq[2*R2_W-1:16];
        ar2s_a_reg <= ar2_prod[47:16];
        item_b_reg <= item_a_reg;
        blo_b_reg  <= blo_next;
        bhi_b_reg  <= bhi_next;
        ar2s_b_reg <= ar2s_a_reg;
        item_c_reg <= item_b_reg;
        z_c_reg    <= z_next;
        item_d_reg <= item_c_reg;
        px_d_reg   <= px_next;
        py_d_reg   <= py_next;
    end

    assign out_vld  = vld_d_reg;
    assign out_item = item_d_reg;
    assign out_px   = px_d_reg;
    assign out_py   = py_d_reg;
endmodule
`default_nettype wire

@@ sv/rdbr_samp.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "radial_distortion_bilinear_remap_unit_macros.svh"
module rdbr_samp import rdbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_vld,
    input  item_t                 in_item,
    input  logic signed [P_W-1:0] in_px,
    input  logic signed [P_W-1:0] in_py,
    output logic                  done,
    output logic [6:0]            out_x,
    output logic [6:0]            out_y,
    output logic [7:0]            out_ch0,
    output logic [7:0]            out_ch1,
    output logic [7:0]            out_ch2,
    output logic [7:0]            out_ch3
);
    function automatic logic [6:0] clamp_coord(input logic signed [35:0] v,
                                               input logic [6:0] lo,
                                               input logic [7:0] hi);
        logic signed [35:0] lo_s;
        logic signed [35:0] hi_s;
        lo_s = $signed({29'b0, lo});
        hi_s = $signed({28'b0, hi}) - 36'sd1;
        priority if (v < lo_s)
        begin
            return lo;
        end
        else if (v > hi_s)
        begin
            return hi_s[6:0];
        end
        else
        begin
            return v[6:0];
        end
    endfunction

    logic signed [35:0]  ix;
    logic signed [35:0]  iy;
    logic [6:0]          xs0;
    logic [6:0]          xs1;
    logic [6:0]          ys0;
    logic [6:0]          ys1;
    logic                is_read;
    logic                is_write;
    logic [3:0]          bank_we;
    logic [BANK_AW-1:0]  waddr;
    logic [BANK_AW-1:0]  raddr [4];
    logic [PIX_W-1:0]    rdata [4];

    logic                vld_e_reg;
    logic [6:0]          x_e_reg;
    logic [6:0]          y_e_reg;
    logic [7:0]          fx_e_reg;
    logic [7:0]          fy_e_reg;
    logic                xp0_e_reg;
    logic                xp1_e_reg;
    logic                yp0_e_reg;
    logic                yp1_e_reg;

    logic [PIX_W-1:0]    nb [4];
    logic [8:0]          wx;
    logic [15:0]         h0_next [4];
    logic [15:0]         h1_next [4];
    logic                vld_f_reg;
    logic [6:0]          x_f_reg;
    logic [6:0]          y_f_reg;
    logic [7:0]          fy_f_reg;
    logic [15:0]         h0_f_reg [4];
    logic [15:0]         h1_f_reg [4];

    logic [8:0]          wy;
    logic [7:0]          ch_next [4];
    logic                done_reg;
    logic [6:0]          out_x_reg;
    logic [6:0]          out_y_reg;
    logic [7:0]          ch_reg [4];

    assign ix       = in_px[P_W-1:16];
    assign iy       = in_py[P_W-1:16];
    assign xs0      = clamp_coord(ix, cfg.lx, cfg.hx);
    assign xs1      = clamp_coord(ix + 36'sd1, cfg.lx, cfg.hx);
    assign ys0      = clamp_coord(iy, cfg.ly, cfg.hy);
    assign ys1      = clamp_coord(iy + 36'sd1, cfg.ly, cfg.hy);
    assign is_read  = in_vld && (in_item.cmd == CMD_READ);
    assign is_write = in_vld && (in_item.cmd == CMD_WRITE);
    assign waddr    = {in_item.y[6:1], in_item.x[6:1]};

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_bank
            logic [6:0] xsel;
            logic [6:0] ysel;

            assign xsel       = (xs0[0] == 1'(g % 2)) ? xs0 : xs1;
            assign ysel       = (ys0[0] == 1'(g / 2)) ? ys0 : ys1;
            assign raddr[g]   = {ysel[6:1], xsel[6:1]};
            assign bank_we[g] = is_write && ({in_item.y[0], in_item.x[0]} == 2'(g));

            rdbr_ram #(
                .WIDTH(PIX_W),
                .DEPTH(BANK_DEPTH)
            ) u_bank (
                .clk   (clk),
                .we    (bank_we[g]),
                .waddr (waddr),
                .wdata (in_item.data),
                .raddr (raddr[g]),
                .rdata (rdata[g])
            );
        end
    endgenerate

    assign nb[0] = rdata[{yp0_e_reg, xp0_e_reg}];
    assign nb[1] = rdata[{yp0_e_reg, xp1_e_reg}];
    assign nb[2] = rdata[{yp1_e_reg, xp0_e_reg}];
    assign nb[3] = rdata[{yp1_e_reg, xp1_e_reg}];
    assign wx    = 9'd256 - {1'b0, fx_e_reg};
    assign wy    = 9'd256 - {1'b0, fy_f_reg};

    generate
        for (g = 0; g < 4; g++)
        begin : g_chan
            logic [16:0] h0_full;
            logic [16:0] h1_full;
            logic [24:0] acc;

            assign h0_full    = nb[0][8*g +: 8] * wx + nb[1][8*g +: 8] * fx_e_reg;
            assign h1_full    = nb[2][8*g +: 8] * wx + nb[3][8*g +: 8] * fx_e_reg;
            assign h0_next[g] = h0_full[15:0];
            assign h1_next[g] = h1_full[15:0];
            assign acc        = h0_f_reg[g] * wy + h1_f_reg[g] * fy_f_reg;
            assign ch_next[g] = (3'(g) < cfg.nch) ? acc[23:16] : 8'd0;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld_e_reg <= is_read;
            vld_f_reg <= vld_e_reg;
            done_reg  <= vld_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_e_reg   <= in_item.x;
        y_e_reg   <= in_item.y;
        fx_e_reg  <= in_px[15:8];
        fy_e_reg  <= in_py[15:8];
        xp0_e_reg <= xs0[0];
        xp1_e_reg <= xs1[0];
        yp0_e_reg <= ys0[0];
        yp1_e_reg <= ys1[0];
        x_f_reg   <= x_e_reg;
        y_f_reg   <= y_e_reg;
        fy_f_reg  <= fy_e_reg;
        h0_f_reg  <= h0_next;
        h1_f_reg  <= h1_next;
        out_x_reg <= x_f_reg;
        out_y_reg <= y_f_reg;
        ch_reg    <= ch_next;
    end

    assign done    = done_reg;
    assign out_x   = out_x_reg;
    assign out_y   = out_y_reg;
    assign out_ch0 = ch_reg[0];
    assign out_ch1 = ch_reg[1];
    assign out_ch2 = ch_reg[2];
    assign out_ch3 = ch_reg[3];

    `RDBR_CHECK(a_one_bank_written, $onehot0(bank_we), "More than one bank written")
    `RDBR_CHECK(a_col_pair, !is_read || xs1 == xs0 || xs1 == xs0 + 7'd1, "Columns not adjacent")
    `RDBR_CHECK(a_row_pair, !is_read || ys1 == ys0 || ys1 == ys0 + 7'd1, "Rows not adjacent")
endmodule
`default_nettype wire

@@ sv/radial_distortion_bilinear_remap_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "radial_distortion_bilinear_remap_unit_macros.svh"
// Radial lens-distortion correction with bilinear resampling over a 128 x 128 frame store.
// An item is taken at every rising edge with start high; busy is always low, so an item
// may be issued in every cycle. A write item (command 0) stores one pixel of four 8-bit
// channels and gives no result. A request item (command 1) inside the region gives one
// result; a request outside the region gives none.
// A result appears on done, out_x, out_y and out_ch0..out_ch3 for exactly one cycle,
// and results keep item order. The receiver cannot stall results.
// Throughput is one item per cycle. The latency is set by the 31-stage radius divider,
// one quotient bit per stage, followed by the distortion polynomial, the four-bank
// frame store read (one bank per row and column parity, one read each per cycle) and
// the two interpolation stages. Writes reach the store at the same stage as reads, so
// every request sees exactly the writes taken before it.
// Configuration is written through cfg_we, cfg_index and cfg_data, by the user only while
// no item is in flight; the block does not enforce this. Reset clears the registers to
// their defaults and empties the pipeline; the frame store is undefined until written.
module radial_distortion_bilinear_remap_unit import rdbr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             command,
    input  logic [6:0]       pos_x,
    input  logic [6:0]       pos_y,
    input  logic [7:0]       in_ch0,
    input  logic [7:0]       in_ch1,
    input  logic [7:0]       in_ch2,
    input  logic [7:0]       in_ch3,
    output logic             done,
    output logic [6:0]       out_x,
    output logic [6:0]       out_y,
    output logic [7:0]       out_ch0,
    output logic [7:0]       out_ch1,
    output logic [7:0]       out_ch2,
    output logic [7:0]       out_ch3
);
    logic signed [20:0] coef_a_reg;
    logic signed [19:0] coef_b_reg;
    logic [9:0]         radius_scale_reg;
    logic [6:0]         region_left_reg;
    logic [6:0]         region_top_reg;
    logic [7:0]         region_right_reg;
    logic [7:0]         region_bottom_reg;
    logic [2:0]         channel_count_reg;

    cfg_t               cfg_next;
    cfg_t               cfg_reg;
    logic [7:0]         hx_cut;
    logic [7:0]         hy_cut;
    logic [8:0]         cx_sum;
    logic [8:0]         cy_sum;
    logic [9:0]         s_eff;

    logic               accept;
    logic               in_region;
    logic               vld0_next;
    item_t              item0_next;
    logic               vld0_reg;
    item_t              item0_reg;
    logic signed [15:0] dx_sq;
    logic signed [15:0] dy_sq;
    logic [15:0]        sq_sum;
    logic               vld1_reg;
    item_t              item1_reg;
    logic [NUM_W-1:0]   num1_reg;

    logic               div_vld;
    item_t              div_item;
    logic [QUOT_W-1:0]  div_quot;
    logic               warp_vld;
    item_t              warp_item;
    logic signed [P_W-1:0] warp_px;
    logic signed [P_W-1:0] warp_py;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg        <= '0;
            coef_b_reg        <= '0;
            radius_scale_reg  <= 10'd1000;
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_right_reg  <= 8'd128;
            region_bottom_reg <= 8'd128;
            channel_count_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF_A:        coef_a_reg        <= cfg_data[20:0];
                REG_COEF_B:        coef_b_reg        <= cfg_data[19:0];
                REG_RADIUS_SCALE:  radius_scale_reg  <= cfg_data[9:0];
                REG_REGION_LEFT:   region_left_reg   <= cfg_data[6:0];
                REG_REGION_TOP:    region_top_reg    <= cfg_data[6:0];
                REG_REGION_RIGHT:  region_right_reg  <= cfg_data[7:0];
                REG_REGION_BOTTOM: region_bottom_reg <= cfg_data[7:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[2:0];
            endcase
        end
    end

    always_comb
    begin
        hx_cut = (region_right_reg > 8'(IMG_WIDTH)) ? 8'(IMG_WIDTH) : region_right_reg;
        hy_cut = (region_bottom_reg > 8'(IMG_HEIGHT)) ? 8'(IMG_HEIGHT) : region_bottom_reg;
        cfg_next.coef_a = coef_a_reg;
        cfg_next.coef_b = coef_b_reg;
        cfg_next.lx     = region_left_reg;
        cfg_next.ly     = region_top_reg;
        cfg_next.hx     = (hx_cut <= {1'b0, region_left_reg})
                          ? {1'b0, region_left_reg} + 8'd1 : hx_cut;
        cfg_next.hy     = (hy_cut <= {1'b0, region_top_reg})
                          ? {1'b0, region_top_reg} + 8'd1 : hy_cut;
        cx_sum          = {2'b0, region_left_reg} + {1'b0, cfg_next.hx};
        cy_sum          = {2'b0, region_top_reg} + {1'b0, cfg_next.hy};
        cfg_next.cx     = cx_sum[7:1];
        cfg_next.cy     = cy_sum[7:1];
        s_eff           = (radius_scale_reg == 10'd0) ? 10'd1 : radius_scale_reg;
        cfg_next.s_sq   = s_eff * s_eff;
        cfg_next.nch    = (channel_count_reg > 3'd4) ? 3'd4 : channel_count_reg;
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign in_region = (pos_x >= cfg_next.lx) && ({1'b0, pos_x} < cfg_next.hx)
                    && (pos_y >= cfg_next.ly) && ({1'b0, pos_y} < cfg_next.hy);

    always_comb
    begin
        item0_next.cmd  = cmd_t'(command);
        item0_next.x    = pos_x;
        item0_next.y    = pos_y;
        item0_next.data = {in_ch3, in_ch2, in_ch1, in_ch0};
        item0_next.dx   = $signed({1'b0, pos_x} - {1'b0, cfg_next.cx});
        item0_next.dy   = $signed({1'b0, pos_y} - {1'b0, cfg_next.cy});
        if (command == CMD_WRITE)
        begin
            vld0_next = accept && ({1'b0, pos_x} < 8'(IMG_WIDTH))
                               && ({1'b0, pos_y} < 8'(IMG_HEIGHT));
        end
        else
        begin
            vld0_next = accept && in_region;
        end
    end

    assign dx_sq  = item0_reg.dx * item0_reg.dx;
    assign dy_sq  = item0_reg.dy * item0_reg.dy;
    assign sq_sum = unsigned'(dx_sq) + unsigned'(dy_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= vld0_next;
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item0_reg <= item0_next;
        item1_reg <= item0_reg;
        num1_reg  <= sq_sum[NUM_W-1:0];
    end

    rdbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld1_reg),
        .in_item  (item1_reg),
        .in_num   (num1_reg),
        .dsq      (cfg_reg.s_sq),
        .out_vld  (div_vld),
        .out_item (div_item),
        .out_quot (div_quot)
    );

    rdbr_warp u_warp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_vld   (div_vld),
        .in_item  (div_item),
        .in_quot  (div_quot),
        .out_vld  (warp_vld),
        .out_item (warp_item),
        .out_px   (warp_px),
        .out_py   (warp_py)
    );

    rdbr_samp u_samp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_vld  (warp_vld),
        .in_item (warp_item),
        .in_px   (warp_px),
        .in_py   (warp_py),
        .done    (done),
        .out_x   (out_x),
        .out_y   (out_y),
        .out_ch0 (out_ch0),
        .out_ch1 (out_ch1),
        .out_ch2 (out_ch2),
        .out_ch3 (out_ch3)
    );

    `RDBR_CHECK(a_write_silent, (start && !busy && command == CMD_WRITE) |-> ##LATENCY !done, "Write item gave a result")
endmodule
`default_nettype wire
